// ===== rtl/atms_pkg.sv =====
// Package for the ATA transfer mode select core: register indexes, drive
// geometry constants and the divide-by-ten reciprocal.
// No dependencies.
package atms_pkg;

	// Configuration register indexes (byte address = 4 * index)
	typedef enum logic [1:0] {
		REG_UDMA_HOST_ALLOWED = 2'd0,
		REG_UDMA_CAP_MODE_TWO = 2'd1,
		REG_UDMA_LIMIT_VALID  = 2'd2,
		REG_UDMA_LIMIT        = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_PIO   = 2'd0,
		KIND_MWDMA = 2'd1,
		KIND_UDMA  = 2'd2
	} xfer_kind_t;

	localparam logic [7:0]  UDMA_LIMIT_RESET = 8'hff;
	localparam logic [7:0]  UDMA_LIMIT_OFF   = 8'hff;
	localparam logic [7:0]  UDMA_FEAT_BASE   = 8'h40;
	localparam logic [7:0]  MWDMA_FEAT_BASE  = 8'h20;

	// Large-drive geometry: 16383 cylinders, 63 sectors, 15 or 16 heads
	localparam logic [15:0] CYL_LARGE     = 16'd16383;
	localparam logic [15:0] CYL_ALT       = 16'd4092;
	localparam logic [15:0] SPT_LARGE     = 16'd63;
	localparam logic [15:0] HEADS_15      = 16'd15;
	localparam logic [15:0] HEADS_16      = 16'd16;
	localparam logic [31:0] MIN_CAP_HD15  = 32'd15481935;   // 16383 * 63 * 15
	localparam logic [31:0] MIN_CAP_HD16  = 32'd16514064;   // 16383 * 63 * 16

	// floor(x / 10) = (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
	localparam logic [31:0] RECIP_TEN   = 32'hcccc_cccd;
	localparam int          RECIP_SHIFT = 35;

endpackage

// ===== rtl/ata_transfer_mode_select_core.sv =====
// ATA transfer mode select core: decodes one IDENTIFY record per transfer into
// transfer mode, addressing mode and capacity. Uses atms_pkg.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  in      | in_valid / in_ready   | udma_modes .. lba48_capacity (12 fields)
//  out     | out_valid / out_ready | pio_mode .. capacity_swapped (7 fields)
//  cfg     | APB psel/penable      | paddr[3:2] register index, pwdata
//
// Four register stages: decode and cyl*heads, times sectors, reciprocal
// multiply for the tenth, compare and select into the output register.
// One record per cycle is sustained while out_ready is high.
// Each stage advances when its successor is empty or advancing, so bubbles
// close up and a stalled output holds only the stages behind it.
// arst_n clears valid bits and configuration flags and sets the UDMA limit to 8'hff.
module ata_transfer_mode_select_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  udma_modes,
	input  logic [7:0]  mwdma_modes,
	input  logic [1:0]  pio_mode_bits,
	input  logic        lba_capable,
	input  logic        lba48_supported,
	input  logic        lba48_enabled,
	input  logic [15:0] cylinders,
	input  logic [15:0] current_cylinders,
	input  logic [15:0] head_count,
	input  logic [15:0] sectors_per_track,
	input  logic [31:0] lba28_capacity,
	input  logic [47:0] lba48_capacity,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  pio_mode,
	output logic [1:0]  transfer_kind,
	output logic [7:0]  dma_feature,
	output logic        lba_mode,
	output logic        lba48_mode,
	output logic [47:0] sector_count,
	output logic        capacity_swapped
);

	// ---------------- configuration ----------------
	logic       udma_host_allowed_q;
	logic       udma_cap_mode_two_q;
	logic       udma_limit_valid_q;
	logic [7:0] udma_limit_q;
	logic       cfg_wr;
	atms_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = atms_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			udma_host_allowed_q <= 1'b0;
			udma_cap_mode_two_q <= 1'b0;
			udma_limit_valid_q  <= 1'b0;
			udma_limit_q        <= atms_pkg::UDMA_LIMIT_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				atms_pkg::REG_UDMA_HOST_ALLOWED: udma_host_allowed_q <= pwdata[0];
				atms_pkg::REG_UDMA_CAP_MODE_TWO: udma_cap_mode_two_q <= pwdata[0];
				atms_pkg::REG_UDMA_LIMIT_VALID:  udma_limit_valid_q  <= pwdata[0];
				atms_pkg::REG_UDMA_LIMIT:        udma_limit_q        <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			atms_pkg::REG_UDMA_HOST_ALLOWED: prdata = {31'd0, udma_host_allowed_q};
			atms_pkg::REG_UDMA_CAP_MODE_TWO: prdata = {31'd0, udma_cap_mode_two_q};
			atms_pkg::REG_UDMA_LIMIT_VALID:  prdata = {31'd0, udma_limit_valid_q};
			atms_pkg::REG_UDMA_LIMIT:        prdata = {24'd0, udma_limit_q};
			default:                         prdata = 32'd0;
		endcase
	end

	// ---------------- stage enables ----------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// ---------------- stage 1 decode ----------------
	logic [2:0] pio_c;
	logic [1:0] kind_c;
	logic [7:0] feat_c;
	logic [2:0] udma_top;
	logic [2:0] udma_m;
	logic [1:0] mw_top;
	logic       udma_use;
	logic       geo_ok;
	logic [31:0] min_cap;
	logic       large_c;

	always_comb begin
		pio_c = 3'd2;
		if (pio_mode_bits[0]) pio_c = 3'd3;
		if (pio_mode_bits[1]) pio_c = 3'd4;

		udma_top = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (udma_modes[i]) udma_top = 3'(i);
		end
		mw_top = 2'd0;
		for (int i = 0; i < 3; i++) begin
			if (mwdma_modes[i]) mw_top = 2'(i);
		end

		udma_m = udma_top;
		if (udma_cap_mode_two_q && udma_m > 3'd2) udma_m = 3'd2;
		// limit below the mode is at most 6, so it fits the mode width
		if (udma_limit_valid_q && {5'd0, udma_m} > udma_limit_q) udma_m = udma_limit_q[2:0];

		udma_use = (udma_modes != 8'd0) && udma_host_allowed_q &&
			!(udma_limit_valid_q && udma_limit_q == atms_pkg::UDMA_LIMIT_OFF);

		if (udma_use) begin
			kind_c = atms_pkg::KIND_UDMA;
			feat_c = atms_pkg::UDMA_FEAT_BASE | {5'd0, udma_m};
		end else if (mwdma_modes != 8'd0) begin
			kind_c = atms_pkg::KIND_MWDMA;
			feat_c = atms_pkg::MWDMA_FEAT_BASE | {6'd0, mw_top};
		end else begin
			kind_c = atms_pkg::KIND_PIO;
			feat_c = 8'd0;
		end

		geo_ok = (cylinders == atms_pkg::CYL_LARGE ||
			(cylinders == atms_pkg::CYL_ALT && current_cylinders == atms_pkg::CYL_LARGE)) &&
			sectors_per_track == atms_pkg::SPT_LARGE &&
			(head_count == atms_pkg::HEADS_15 || head_count == atms_pkg::HEADS_16);
		min_cap = (head_count == atms_pkg::HEADS_15) ? atms_pkg::MIN_CAP_HD15
			: atms_pkg::MIN_CAP_HD16;
		large_c = geo_ok && (lba28_capacity >= min_cap);
	end

	logic [2:0]  pio_s1, pio_s2, pio_s3;
	logic [1:0]  kind_s1, kind_s2, kind_s3;
	logic [7:0]  feat_s1, feat_s2, feat_s3;
	logic        lba_s1, lba_s2, lba_s3;
	logic        l48_s1, l48_s2, l48_s3;
	logic        large_s1, large_s2, large_s3;
	logic [31:0] cap28_s1, cap28_s2;
	logic [47:0] cap48_s1, cap48_s2, cap48_s3;
	logic [31:0] chp_s1;
	logic [15:0] spt_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			pio_s1   <= pio_c;
			kind_s1  <= kind_c;
			feat_s1  <= feat_c;
			lba_s1   <= lba_capable;
			l48_s1   <= lba48_supported && lba48_enabled;
			large_s1 <= large_c;
			cap28_s1 <= lba28_capacity;
			cap48_s1 <= lba48_capacity;
			chp_s1   <= {16'd0, cylinders} * {16'd0, head_count};
			spt_s1   <= sectors_per_track;
		end
	end

	// ---------------- stage 2: full CHS product ----------------
	logic [47:0] full_s2, full_s3;

	always_ff @(posedge clk) begin
		if (en2) begin
			pio_s2   <= pio_s1;
			kind_s2  <= kind_s1;
			feat_s2  <= feat_s1;
			lba_s2   <= lba_s1;
			l48_s2   <= l48_s1;
			large_s2 <= large_s1;
			cap28_s2 <= cap28_s1;
			cap48_s2 <= cap48_s1;
			full_s2  <= {16'd0, chp_s1} * {32'd0, spt_s1};
		end
	end

	// ---------------- stage 3: tenth by reciprocal, differences ----------------
	logic [31:0] chs2;
	logic [31:0] swap2;
	logic [63:0] recip_s3;
	logic [31:0] d_dir_s3, d_swp_s3;
	logic [31:0] cap_s3, swap_s3;

	assign chs2  = full_s2[31:0];
	assign swap2 = {cap28_s2[15:0], cap28_s2[31:16]};

	always_ff @(posedge clk) begin
		if (en3) begin
			pio_s3   <= pio_s2;
			kind_s3  <= kind_s2;
			feat_s3  <= feat_s2;
			lba_s3   <= lba_s2;
			l48_s3   <= l48_s2;
			large_s3 <= large_s2;
			cap48_s3 <= cap48_s2;
			full_s3  <= full_s2;
			cap_s3   <= cap28_s2;
			swap_s3  <= swap2;
			recip_s3 <= {32'd0, chs2} * {32'd0, atms_pkg::RECIP_TEN};
			d_dir_s3 <= cap28_s2 - chs2;
			d_swp_s3 <= swap2 - chs2;
		end
	end

	// ---------------- stage 4: compare and select ----------------
	logic [28:0] tenth3;
	logic        dir_ok, swp_ok;
	logic [47:0] count_c;
	logic        swapped_c;

	assign tenth3 = recip_s3[63:atms_pkg::RECIP_SHIFT];
	assign dir_ok = d_dir_s3 < {3'd0, tenth3};
	assign swp_ok = d_swp_s3 < {3'd0, tenth3};

	always_comb begin
		swapped_c = 1'b0;
		if (l48_s3) begin
			count_c = cap48_s3;
		end else if (lba_s3 && (large_s3 || dir_ok)) begin
			count_c = {16'd0, cap_s3};
		end else if (lba_s3 && swp_ok) begin
			count_c   = {16'd0, swap_s3};
			swapped_c = 1'b1;
		end else begin
			count_c = full_s3;
		end
	end

	logic [2:0]  pio_s4;
	logic [1:0]  kind_s4;
	logic [7:0]  feat_s4;
	logic        lba_s4, l48_s4, swapped_s4;
	logic [47:0] count_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			pio_s4     <= pio_s3;
			kind_s4    <= kind_s3;
			feat_s4    <= feat_s3;
			lba_s4     <= lba_s3;
			l48_s4     <= l48_s3;
			count_s4   <= count_c;
			swapped_s4 <= swapped_c;
		end
	end

	assign out_valid        = v_s4;
	assign pio_mode         = pio_s4;
	assign transfer_kind    = kind_s4;
	assign dma_feature      = feat_s4;
	assign lba_mode         = lba_s4;
	assign lba48_mode       = l48_s4;
	assign sector_count     = count_s4;
	assign capacity_swapped = swapped_s4;

	// ---------------- assertions ----------------
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is ready");

	a_pio_feat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transfer_kind == atms_pkg::KIND_PIO |-> dma_feature == 8'd0)
		else $error("dma feature set for PIO-only result");

	a_udma_feat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transfer_kind == atms_pkg::KIND_UDMA |->
			dma_feature[7:3] == atms_pkg::UDMA_FEAT_BASE[7:3])
		else $error("ultra DMA feature byte malformed");

	a_swap_lba: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && capacity_swapped |-> lba_mode && !lba48_mode &&
			sector_count[47:32] == 16'd0)
		else $error("swapped capacity outside 28-bit LBA path");

	a_valid_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !out_valid |=> out_valid)
		else $error("stage 3 item not moved to empty output");

endmodule
